// ===== rtl/dtlv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtlv_pkg
// Shared types and constants of the DHCPv6 option TLV deframer.
// ----------------------------------------------------------------------------
package dtlv_pkg;

    // Width of the running byte offset; wraps modulo 2^OFFSET_BITS.
    localparam int OFFSET_BITS = 16;
    localparam logic [OFFSET_BITS-1:0] POS_ONE = 1;

    // Result queue
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_OPTION       = 2'd0,
        KIND_OK           = 2'd1,
        KIND_TRUNC_HEADER = 2'd2,
        KIND_TRUNC_DATA   = 2'd3
    } rec_kind_t;

    typedef struct packed {
        rec_kind_t   kind;
        logic [15:0] code;
        logic [15:0] length;
        logic [15:0] offset;
        logic        last;
    } rec_t;

    // Up to two records per item; en1 only together with en0.
    typedef struct packed {
        logic en0;
        logic en1;
        rec_t rec0;
        rec_t rec1;
    } push_t;

endpackage
`default_nettype wire

// ===== rtl/dtlv_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtlv_parser
// Header gathering, data countdown and record generation, one byte per cycle while accept is high.
// ----------------------------------------------------------------------------
module dtlv_parser
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     data_byte,
    input  wire logic           last_byte,
    output dtlv_pkg::push_t     push
);

    logic [1:0]                       hdr_cnt_reg, hdr_cnt_next;
    logic                             in_data_reg, in_data_next;
    logic [15:0]                      code_acc_reg, code_acc_next;
    logic [15:0]                      length_acc_reg, length_acc_next;
    logic [15:0]                      remaining_reg, remaining_next;
    logic [dtlv_pkg::OFFSET_BITS-1:0] byte_pos_reg, byte_pos_next;
    logic [dtlv_pkg::OFFSET_BITS-1:0] opt_start_reg, opt_start_next;

    logic        done;
    logic [1:0]  hdr_cnt_upd;
    logic        in_data_upd;
    logic [15:0] remaining_dec;
    dtlv_pkg::rec_t opt_rec;
    dtlv_pkg::rec_t status_rec;

    assign remaining_dec = remaining_reg - 16'd1;

    always_comb
    begin
        done            = 1'b0;
        hdr_cnt_upd     = hdr_cnt_reg;
        in_data_upd     = in_data_reg;
        code_acc_next   = code_acc_reg;
        length_acc_next = length_acc_reg;
        remaining_next  = remaining_reg;
        opt_start_next  = opt_start_reg;

        if (in_data_reg)
        begin
            remaining_next = remaining_dec;
            done           = (remaining_dec == 16'd0);
        end
        else
        begin
            unique case (hdr_cnt_reg)
                2'd0:
                begin
                    opt_start_next = byte_pos_reg;
                    code_acc_next  = {data_byte, 8'h00};
                    hdr_cnt_upd    = 2'd1;
                end
                2'd1:
                begin
                    code_acc_next = {code_acc_reg[15:8], data_byte};
                    hdr_cnt_upd   = 2'd2;
                end
                2'd2:
                begin
                    length_acc_next = {data_byte, 8'h00};
                    hdr_cnt_upd     = 2'd3;
                end
                default:
                begin
                    length_acc_next = {length_acc_reg[15:8], data_byte};
                    hdr_cnt_upd     = 2'd0;
                    if ({length_acc_reg[15:8], data_byte} == 16'd0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        in_data_upd    = 1'b1;
                        remaining_next = {length_acc_reg[15:8], data_byte};
                    end
                end
            endcase
        end

        if (done)
        begin
            in_data_upd = 1'b0;
            hdr_cnt_upd = 2'd0;
        end

        hdr_cnt_next  = hdr_cnt_upd;
        in_data_next  = in_data_upd;
        byte_pos_next = byte_pos_reg + dtlv_pkg::POS_ONE;
    end

    always_comb
    begin
        opt_rec.kind   = dtlv_pkg::KIND_OPTION;
        opt_rec.code   = code_acc_next;
        opt_rec.length = length_acc_next;
        opt_rec.offset = 16'(opt_start_next);
        opt_rec.last   = 1'b0;

        status_rec.code   = 16'd0;
        status_rec.length = 16'd0;
        status_rec.last   = 1'b1;
        priority if (in_data_upd)
        begin
            status_rec.kind   = dtlv_pkg::KIND_TRUNC_DATA;
            status_rec.offset = 16'(opt_start_next);
        end
        else if (hdr_cnt_upd != 2'd0)
        begin
            status_rec.kind   = dtlv_pkg::KIND_TRUNC_HEADER;
            status_rec.offset = 16'(opt_start_next);
        end
        else
        begin
            status_rec.kind   = dtlv_pkg::KIND_OK;
            status_rec.offset = 16'd0;
        end

        // Records are packed from slot 0: option first, then status.
        push.en0  = accept && (done || last_byte);
        push.en1  = accept && done && last_byte;
        push.rec0 = done ? opt_rec : status_rec;
        push.rec1 = status_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg    <= 2'd0;
            in_data_reg    <= 1'b0;
            code_acc_reg   <= 16'd0;
            length_acc_reg <= 16'd0;
            remaining_reg  <= 16'd0;
            byte_pos_reg   <= '0;
            opt_start_reg  <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                // final byte: back to a fresh buffer at offset 0
                hdr_cnt_reg    <= 2'd0;
                in_data_reg    <= 1'b0;
                code_acc_reg   <= 16'd0;
                length_acc_reg <= 16'd0;
                remaining_reg  <= 16'd0;
                byte_pos_reg   <= '0;
                opt_start_reg  <= '0;
            end
            else
            begin
                hdr_cnt_reg    <= hdr_cnt_next;
                in_data_reg    <= in_data_next;
                code_acc_reg   <= code_acc_next;
                length_acc_reg <= length_acc_next;
                remaining_reg  <= remaining_next;
                byte_pos_reg   <= byte_pos_next;
                opt_start_reg  <= opt_start_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dtlv_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtlv_outq
// Small result queue: takes up to two records per cycle, hands out one while out_stall is low.
// ----------------------------------------------------------------------------
module dtlv_outq
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dtlv_pkg::push_t push,
    output logic                 full,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output dtlv_pkg::rec_t       out_rec
);

    dtlv_pkg::rec_t                 mem_reg [dtlv_pkg::QDEPTH];
    logic [dtlv_pkg::QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dtlv_pkg::QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dtlv_pkg::QCNT_BITS-1:0] count_reg, count_next;
    logic [dtlv_pkg::QPTR_BITS-1:0] wr_ptr_inc;
    logic [dtlv_pkg::QCNT_BITS-1:0] n_push;
    logic                           pop;

    assign wr_ptr_inc = wr_ptr_reg + dtlv_pkg::QPTR_BITS'(1);
    assign n_push     = dtlv_pkg::QCNT_BITS'(push.en0) + dtlv_pkg::QCNT_BITS'(push.en1);
    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid && !out_stall;
    assign out_rec    = mem_reg[rd_ptr_reg];
    // need room for two records before taking the next item
    assign full       = (count_reg > dtlv_pkg::QCNT_BITS'(dtlv_pkg::QDEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + dtlv_pkg::QPTR_BITS'(n_push);
    assign rd_ptr_next = rd_ptr_reg + dtlv_pkg::QPTR_BITS'(pop);
    assign count_next  = count_reg + n_push - dtlv_pkg::QCNT_BITS'(pop);

    always_ff @(posedge clk)
    begin
        if (push.en0)
        begin
            mem_reg[wr_ptr_reg] <= push.rec0;
        end
        if (push.en1)
        begin
            mem_reg[wr_ptr_inc] <= push.rec1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dtlv_pkg::QCNT_BITS'(dtlv_pkg::QDEPTH))
        else $error("result queue count out of range");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.en1 |-> push.en0)
        else $error("second record pushed without first");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push.en0)
        else $error("record pushed while queue lacks room");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push.en0) |=> (count_reg == $past(count_reg) - dtlv_pkg::QCNT_BITS'(1)))
        else $error("queue count did not drop on pop");
`endif

endmodule
`default_nettype wire

// ===== rtl/dhcpv6_option_tlv_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhcpv6_option_tlv_deframer
// Splits a DHCPv6 options area, one byte per item, into option records and
// one status record per buffer.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry data_byte and last_byte (final byte
// of the buffer). Output channel: out_valid/out_stall carry one record:
// rec_kind, tlv_code, option_length, option_offset, is_last.
// A byte is taken in each cycle with in_valid high and in_stall low. Its
// records join a four-entry result queue, reach the output in order from
// the next cycle on; a final byte that ends an option yields two records.
// in_stall rises only when the queue has fewer than two free entries, so a
// receiver that stalls backs the input up once three records wait; nothing
// is dropped. After the final byte the parser restarts at offset 0.
// Reset clears the parser state and empties the queue, so in_stall is low
// when reset ends.
// ----------------------------------------------------------------------------
module dhcpv6_option_tlv_deframer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       rec_kind,
    output logic [15:0]      tlv_code,
    output logic [15:0]      option_length,
    output logic [15:0]      option_offset,
    output logic             is_last
);

    dtlv_pkg::push_t push;
    dtlv_pkg::rec_t  out_rec;
    logic            full;
    logic            accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    dtlv_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push)
    );

    dtlv_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rec   (out_rec)
    );

    assign rec_kind      = out_rec.kind;
    assign tlv_code      = out_rec.code;
    assign option_length = out_rec.length;
    assign option_offset = out_rec.offset;
    assign is_last       = out_rec.last;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the DHCPv6 option TLV deframer. It runs a table of directed buffers,
// then random buffers, mostly well formed with some cut short and some noise.
// Every record is checked field by field against the bench's byte-level parser
// model or a typed table row. Both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RAND_ITEMS  = 1400;
    localparam int CYCLE_LIMIT = 600_000;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 16;
    localparam int NUM_DIR     = 26;
    localparam dtlv_pkg::rec_t NO_REC = '0;

    typedef struct packed {
        logic [7:0]     data;
        logic           fin;
        logic           typed;
        dtlv_pkg::rec_t rec;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  rec_kind;
    logic [15:0] tlv_code;
    logic [15:0] option_length;
    logic [15:0] option_offset;
    logic        is_last;

    // parser model state
    logic [1:0]                       hdr_cnt;
    logic                             in_payload;
    logic [15:0]                      cur_code;
    logic [15:0]                      cur_len;
    logic [15:0]                      payload_left;
    logic [dtlv_pkg::OFFSET_BITS-1:0] byte_pos;
    logic [dtlv_pkg::OFFSET_BITS-1:0] opt_start;

    dtlv_pkg::rec_t step_recs[$];
    dtlv_pkg::rec_t pending_recs[$];
    logic [7:0]     buf_q[$];
    stim_row_t      dir_rows [NUM_DIR];
    dtlv_pkg::rec_t got_rec;

    int err_cnt   = 0;
    int cycle_cnt = 0;
    int rand_cnt  = 0;
    int hold_left = 0;
    bit hold_req  = 1'b0;
    bit tx_quiet  = 1'b0;
    bit rx_quiet  = 1'b0;

    dhcpv6_option_tlv_deframer u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .rec_kind      (rec_kind),
        .tlv_code      (tlv_code),
        .option_length (option_length),
        .option_offset (option_offset),
        .is_last       (is_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic dtlv_pkg::rec_t make_rec(dtlv_pkg::rec_kind_t k, logic [15:0] c,
                                                logic [15:0] l, logic [15:0] o, logic f);
        dtlv_pkg::rec_t r;
        r.kind   = k;
        r.code   = c;
        r.length = l;
        r.offset = o;
        r.last   = f;
        return r;
    endfunction

    task automatic clear_parser();
        hdr_cnt      = 2'd0;
        in_payload   = 1'b0;
        cur_code     = 16'h0000;
        cur_len      = 16'h0000;
        payload_left = 16'h0000;
        byte_pos     = '0;
        opt_start    = '0;
    endtask

    // Records caused by one byte land in step_recs.
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        logic done;
        done = 1'b0;
        step_recs.delete();
        if (in_payload)
        begin
            payload_left = payload_left - 16'd1;
            if (payload_left == 16'd0)
                done = 1'b1;
        end
        else
        begin
            case (hdr_cnt)
                2'd0:
                begin
                    opt_start = byte_pos;
                    cur_code  = {b, 8'h00};
                    hdr_cnt   = 2'd1;
                end
                2'd1:
                begin
                    cur_code[7:0] = b;
                    hdr_cnt       = 2'd2;
                end
                2'd2:
                begin
                    cur_len = {b, 8'h00};
                    hdr_cnt = 2'd3;
                end
                default:
                begin
                    cur_len[7:0] = b;
                    hdr_cnt      = 2'd0;
                    if (cur_len == 16'd0)
                        done = 1'b1;
                    else
                    begin
                        in_payload   = 1'b1;
                        payload_left = cur_len;
                    end
                end
            endcase
        end
        if (done)
        begin
            step_recs.push_back(make_rec(dtlv_pkg::KIND_OPTION, cur_code, cur_len,
                                         opt_start[15:0], 1'b0));
            in_payload = 1'b0;
            hdr_cnt    = 2'd0;
        end
        byte_pos = byte_pos + dtlv_pkg::POS_ONE;
        if (fin)
        begin
            if (in_payload)
                step_recs.push_back(make_rec(dtlv_pkg::KIND_TRUNC_DATA, 16'h0, 16'h0,
                                             opt_start[15:0], 1'b1));
            else if (hdr_cnt != 2'd0)
                step_recs.push_back(make_rec(dtlv_pkg::KIND_TRUNC_HEADER, 16'h0, 16'h0,
                                             opt_start[15:0], 1'b1));
            else
                step_recs.push_back(make_rec(dtlv_pkg::KIND_OK, 16'h0, 16'h0,
                                             16'h0, 1'b1));
            clear_parser();
        end
    endtask

    // Called and returns at a falling edge; the item is taken at a rising edge.
    // A typed record replaces the last record the model gives for that item.
    task automatic send_byte(input logic [7:0] d, input logic fin, input logic typed,
                             input dtlv_pkg::rec_t typed_rec);
        while (!tx_quiet && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        last_byte <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_byte(d, fin);
        if (typed)
        begin
            if (step_recs.size() != 0)
                void'(step_recs.pop_back());
            step_recs.push_back(typed_rec);
        end
        foreach (step_recs[i])
            pending_recs.push_back(step_recs[i]);
        @(negedge clk);
    endtask

    task automatic send_buffer();
        foreach (buf_q[i])
            send_byte(buf_q[i], i == buf_q.size() - 1, 1'b0, NO_REC);
    endtask

    task automatic push_option(input logic [15:0] code, input int len);
        buf_q.push_back(code[15:8]);
        buf_q.push_back(code[7:0]);
        buf_q.push_back(len[15:8]);
        buf_q.push_back(len[7:0]);
        repeat (len)
            buf_q.push_back(8'($urandom));
    endtask

    // Mostly well-formed options areas; some cut short, some raw noise.
    task automatic make_buffer();
        int pick;
        int keep;
        int len;
        int code_sel;
        logic [15:0] code;
        buf_q.delete();
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            repeat ($urandom_range(1, 12))
                buf_q.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                code_sel = $urandom_range(7);
                code = (code_sel == 0) ? 16'h0000 :
                       (code_sel == 1) ? 16'hFFFF : 16'($urandom);
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
                push_option(code, len);
            end
            if (pick < 30 && buf_q.size() > 1)
            begin
                keep = $urandom_range(1, buf_q.size() - 1);
                while (buf_q.size() > keep)
                    void'(buf_q.pop_back());
            end
        end
    endtask

    // Receiver: random stalls, one long hold-off on request, quiet stretches.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (rx_quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 21);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_recs.size() == 0)
            begin
                $error("unexpected record: kind %0d code %h length %h offset %h last %b",
                       rec_kind, tlv_code, option_length, option_offset, is_last);
                err_cnt++;
            end
            else
            begin
                got_rec = pending_recs.pop_front();
                if (rec_kind !== got_rec.kind)
                begin
                    $error("rec_kind: expected %0d, got %0d", got_rec.kind, rec_kind);
                    err_cnt++;
                end
                if (tlv_code !== got_rec.code)
                begin
                    $error("tlv_code: expected %h, got %h", got_rec.code, tlv_code);
                    err_cnt++;
                end
                if (option_length !== got_rec.length)
                begin
                    $error("option_length: expected %h, got %h", got_rec.length,
                           option_length);
                    err_cnt++;
                end
                if (option_offset !== got_rec.offset)
                begin
                    $error("option_offset: expected %h, got %h", got_rec.offset,
                           option_offset);
                    err_cnt++;
                end
                if (is_last !== got_rec.last)
                begin
                    $error("is_last: expected %b, got %b", got_rec.last, is_last);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        bit held;
        bit drained;
        held      = 1'b0;
        drained   = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        last_byte = 1'b0;
        clear_parser();

        dir_rows = '{
            // one-byte buffer: header cut after its first byte
            '{8'hFF, 1'b1, 1'b1,
              '{dtlv_pkg::KIND_TRUNC_HEADER, 16'h0, 16'h0, 16'h0, 1'b1}},
            // zero-length option, done on its fourth header byte
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b1, '{dtlv_pkg::KIND_OPTION, 16'h0, 16'h0, 16'h0, 1'b0}},
            // code 0xFFFF, one data byte, which is also the final byte
            '{8'hFF, 1'b0, 1'b0, NO_REC},
            '{8'hFF, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h01, 1'b0, 1'b0, NO_REC},
            '{8'hAB, 1'b1, 1'b1, '{dtlv_pkg::KIND_OK, 16'h0, 16'h0, 16'h0, 1'b1}},
            // data cut short
            '{8'h12, 1'b0, 1'b0, NO_REC},
            '{8'h34, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h05, 1'b0, 1'b0, NO_REC},
            '{8'h01, 1'b0, 1'b0, NO_REC},
            '{8'h02, 1'b1, 1'b1,
              '{dtlv_pkg::KIND_TRUNC_DATA, 16'h0, 16'h0, 16'h0, 1'b1}},
            // header cut after the code
            '{8'hAA, 1'b0, 1'b0, NO_REC},
            '{8'h55, 1'b1, 1'b1,
              '{dtlv_pkg::KIND_TRUNC_HEADER, 16'h0, 16'h0, 16'h0, 1'b1}},
            // zero-length option ending the buffer: option, then status
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h01, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h00, 1'b1, 1'b1, '{dtlv_pkg::KIND_OK, 16'h0, 16'h0, 16'h0, 1'b1}},
            // maximum length, buffer ends right after the header
            '{8'h00, 1'b0, 1'b0, NO_REC},
            '{8'h07, 1'b0, 1'b0, NO_REC},
            '{8'hFF, 1'b0, 1'b0, NO_REC},
            '{8'hFF, 1'b1, 1'b1,
              '{dtlv_pkg::KIND_TRUNC_DATA, 16'h0, 16'h0, 16'h0, 1'b1}}
        };

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIR; i++)
            send_byte(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].typed,
                      dir_rows[i].rec);

        while (rand_cnt < RAND_ITEMS)
        begin
            if (!held && rand_cnt >= 300)
            begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (!drained && rand_cnt >= 700)
            begin
                drained = 1'b1;
                in_valid <= 1'b0;
                while (pending_recs.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            tx_quiet = (rand_cnt >= 900 && rand_cnt < 1150);
            rx_quiet = tx_quiet;
            make_buffer();
            send_buffer();
            rand_cnt += buf_q.size();
        end

        in_valid <= 1'b0;
        rx_quiet = 1'b1;
        while (pending_recs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (pending_recs.size() != 0)
        begin
            $error("%0d records never arrived", pending_recs.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
